@@ src/shlm_pkg.sv @@
package shlm_pkg;

   // Line bytes kept for matching; later bytes only count toward the length.
   localparam int unsigned PrefixDepth = 5;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned LenWidth    = 8;

   localparam logic [LenWidth-1:0]   LEN_MAX   = '1;
   localparam logic [CountWidth-1:0] COUNT_MAX = '1;

   localparam logic [15:0] LIMIT_RESET   = 16'd250;
   localparam logic [7:0]  PENALTY_RESET = 8'd15;

   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_K       = 8'h4B;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_I       = 8'h49;
   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_E       = 8'h45;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   localparam logic [2:0] TRIP_STATE_CLEAR  = 3'd0;
   localparam logic [2:0] TRIP_STATE_REMOTE = 3'd3;

   typedef enum logic [1:0] {
      OP_RX_BYTE   = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_SEND_CMD  = 2'd2,
      OP_MONITOR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      OUTCOME_NONE      = 2'd0,
      OUTCOME_ACK_OK    = 2'd1,
      OUTCOME_ACK_WRONG = 2'd2,
      OUTCOME_OTHER     = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      TRIP_REQ_NONE     = 2'd0,
      TRIP_REQ_REMOTE   = 2'd1,
      TRIP_REQ_ACK_FAIL = 2'd2
   } trip_req_type;

   typedef enum logic {
      CSR_WRONG_ACK_LIMIT    = 1'b0,
      CSR_MISSED_ACK_PENALTY = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] rx_byte;
      logic [7:0] command_char;
      logic [2:0] trip_state;
      logic       heartbeat_level;
   } item_type;

   // What the line buffer tells the ack controller about the line so far.
   typedef struct packed {
      logic       starts_ack;
      logic       starts_trip;
      logic       ack_form;
      logic [7:0] ack_char;
   } line_status_type;

   typedef struct packed {
      logic                  tx_valid;
      logic [7:0]            tx_char;
      outcome_type           line_outcome;
      logic                  command_accepted;
      trip_req_type          trip_request;
      logic [CountWidth-1:0] wrong_count_now;
   } result_type;

endpackage

@@ src/shlm_line_buf.sv @@
module shlm_line_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  shlm_pkg::item_type       item,
   output shlm_pkg::line_status_type status
);
   import shlm_pkg::*;

   logic [7:0]          prefix_ff [PrefixDepth];
   logic [7:0]          prefix_in [PrefixDepth];
   logic [LenWidth-1:0] length_ff;
   logic [LenWidth-1:0] length_in;
   logic                is_byte;
   logic                is_newline;

   assign is_byte    = (item.operation == OP_RX_BYTE);
   assign is_newline = (item.rx_byte == CHAR_NEWLINE);

   // A line ends at newline and starts empty again; other bytes append.
   always_comb begin
      length_in = length_ff;
      for (int i = 0; i < PrefixDepth; i++) begin
         prefix_in[i] = prefix_ff[i];
      end
      if (is_byte) begin
         if (is_newline) begin
            length_in = '0;
            for (int i = 0; i < PrefixDepth; i++) begin
               prefix_in[i] = '0;
            end
         end else begin
            for (int i = 0; i < PrefixDepth; i++) begin
               if (length_ff == LenWidth'(i)) begin
                  prefix_in[i] = item.rx_byte;
               end
            end
            if (length_ff != LEN_MAX) begin
               length_in = length_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         for (int i = 0; i < PrefixDepth; i++) begin
            prefix_ff[i] <= '0;
         end
      end else if (step_en) begin
         length_ff <= length_in;
         for (int i = 0; i < PrefixDepth; i++) begin
            prefix_ff[i] <= prefix_in[i];
         end
      end
   end

   assign status.starts_ack  = (length_ff >= LenWidth'(3)) && (prefix_ff[0] == CHAR_A)
                               && (prefix_ff[1] == CHAR_C) && (prefix_ff[2] == CHAR_K);
   assign status.starts_trip = (length_ff >= LenWidth'(4)) && (prefix_ff[0] == CHAR_T)
                               && (prefix_ff[1] == CHAR_R) && (prefix_ff[2] == CHAR_I)
                               && (prefix_ff[3] == CHAR_P);
   assign status.ack_form    = (length_ff == LenWidth'(PrefixDepth))
                               && (prefix_ff[3] == CHAR_SPACE);
   assign status.ack_char    = prefix_ff[4];

endmodule

@@ src/shlm_ack_ctrl.sv @@
module shlm_ack_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  shlm_pkg::item_type        item,
   input  shlm_pkg::line_status_type status,
   input  logic [15:0]               wrong_ack_limit,
   input  logic [7:0]                missed_ack_penalty,
   output shlm_pkg::result_type      result
);
   import shlm_pkg::*;

   logic                  pending_ff;
   logic                  pending_in;
   logic [7:0]            expected_ff;
   logic [7:0]            expected_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [CountWidth-1:0] add_amount;
   logic                  add_en;
   logic [CountWidth:0]   count_sum;
   logic [CountWidth-1:0] count_sat;
   logic [7:0]            beat_char;
   logic                  tripped_local;

   assign count_sum = {1'b0, count_ff} + {1'b0, add_amount};
   assign count_sat = count_sum[CountWidth] ? COUNT_MAX : count_sum[CountWidth-1:0];

   assign tripped_local = (item.trip_state != TRIP_STATE_CLEAR)
                          && (item.trip_state != TRIP_STATE_REMOTE);
   assign beat_char = tripped_local ? CHAR_E
                                    : (item.heartbeat_level ? CHAR_PLUS : CHAR_MINUS);

   always_comb begin
      pending_in  = pending_ff;
      expected_in = expected_ff;
      add_en      = 1'b0;
      add_amount  = CountWidth'(1);
      result      = '{tx_valid: 1'b0, tx_char: 8'h00, line_outcome: OUTCOME_NONE,
                      command_accepted: 1'b0, trip_request: TRIP_REQ_NONE,
                      wrong_count_now: count_ff};
      case (item.operation)
         OP_RX_BYTE: begin
            if (item.rx_byte == CHAR_NEWLINE) begin
               if (status.starts_ack) begin
                  if (pending_ff && status.ack_form && (status.ack_char == expected_ff)) begin
                     result.line_outcome = OUTCOME_ACK_OK;
                  end else begin
                     add_en              = 1'b1;
                     result.line_outcome = OUTCOME_ACK_WRONG;
                  end
                  pending_in = 1'b0;
               end else if (status.starts_trip) begin
                  result.trip_request = TRIP_REQ_REMOTE;
               end else begin
                  result.line_outcome = OUTCOME_OTHER;
               end
            end
         end
         OP_HEARTBEAT: begin
            result.tx_valid = 1'b1;
            result.tx_char  = beat_char;
            if (!pending_ff) begin
               pending_in  = 1'b1;
               expected_in = beat_char;
            end else begin
               add_en     = 1'b1;
               add_amount = CountWidth'(missed_ack_penalty);
            end
         end
         OP_SEND_CMD: begin
            if (!pending_ff) begin
               result.tx_valid         = 1'b1;
               result.tx_char          = item.command_char;
               result.command_accepted = 1'b1;
               pending_in              = 1'b1;
               expected_in             = item.command_char;
            end else begin
               add_en = 1'b1;
            end
         end
         OP_MONITOR: begin
            if ((count_ff > wrong_ack_limit) && (item.trip_state == TRIP_STATE_CLEAR)) begin
               result.trip_request = TRIP_REQ_ACK_FAIL;
            end
         end
         default: begin
         end
      endcase

      // A correct ack clears the count; every other penalty saturates.
      if (result.line_outcome == OUTCOME_ACK_OK) begin
         count_in = '0;
      end else if (add_en) begin
         count_in = count_sat;
      end else begin
         count_in = count_ff;
      end
      result.wrong_count_now = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         expected_ff <= '0;
         count_ff    <= '0;
      end else if (step_en) begin
         pending_ff  <= pending_in;
         expected_ff <= expected_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ src/safety_link_heartbeat_monitor.sv @@
// Channel   | Direction | Ports                        | Beat contents
// ----------+-----------+------------------------------+-------------------------------------
// request   | in        | req_tvalid/tready/tdata/tuser | one operation: byte, tick or command
// response  | out       | rsp_tvalid/tready/tdata       | one result for every request beat
// registers | in        | csr_wr_en/csr_index/csr_wdata | limit and penalty, write only
//
// A request beat is captured in the input register and resolved once the response
// register is free or emptying, when its result is loaded into it; one beat per
// cycle is sustained while the response side is ready.
// The resolve step is one pass through the line matcher and the ack controller.
// Reset is synchronous: the line, the pending ack and the count clear, the limit
// returns to 250 and the penalty to 15.
// A stalled response holds the resolved beat; the input register keeps accepting
// until it too is full, so the request side stops one beat after the response side.
module safety_link_heartbeat_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rx_byte [7:0], command_char [15:8], trip_state [18:16], heartbeat_level [19],
   // zero [23:20]
   input  logic [23:0] req_tdata,
   // operation [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_valid [0], tx_char [8:1], line_outcome [10:9], command_accepted [11],
   // trip_request [13:12], wrong_count_now [29:14], zero [31:30]
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import shlm_pkg::*;

   logic                      item_valid_ff;
   item_type                  item_ff;
   logic                      rsp_valid_ff;
   result_type                rsp_ff;
   logic                      step_en;
   logic [15:0]               limit_ff;
   logic [7:0]                penalty_ff;
   line_status_type           line_status;
   result_type                result;

   // The held item resolves whenever the response register is free or emptying.
   assign step_en    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.operation       <= op_type'(req_tuser);
         item_ff.rx_byte         <= req_tdata[7:0];
         item_ff.command_char    <= req_tdata[15:8];
         item_ff.trip_state      <= req_tdata[18:16];
         item_ff.heartbeat_level <= req_tdata[19];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         penalty_ff <= PENALTY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WRONG_ACK_LIMIT:    limit_ff   <= csr_wdata;
            CSR_MISSED_ACK_PENALTY: penalty_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   shlm_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .status  (line_status)
   );

   shlm_ack_ctrl u_ack_ctrl (
      .clock              (clock),
      .reset              (reset),
      .step_en            (step_en),
      .item               (item_ff),
      .status             (line_status),
      .wrong_ack_limit    (limit_ff),
      .missed_ack_penalty (penalty_ff),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.wrong_count_now, rsp_ff.trip_request,
                        rsp_ff.command_accepted, rsp_ff.line_outcome,
                        rsp_ff.tx_char, rsp_ff.tx_valid};

endmodule

@@ src/shlm_checker.sv @@
module shlm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import shlm_pkg::*;

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A taken command is always transmitted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[0])
      else $error("accepted command without transmit");

   // A correct ack leaves the count at zero and transmits nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:9] == OUTCOME_ACK_OK)
      |-> (rsp_tdata[29:14] == '0) && !rsp_tdata[0])
      else $error("correct ack with nonzero count or transmit");

   // A remote trip line carries no line outcome and no transmit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[13:12] == TRIP_REQ_REMOTE)
      |-> (rsp_tdata[10:9] == OUTCOME_NONE) && !rsp_tdata[0])
      else $error("remote trip mixed with other results");

endmodule

bind safety_link_heartbeat_monitor shlm_checker u_shlm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/safety_link_heartbeat_monitor_tb.sv @@
module safety_link_heartbeat_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shlm_pkg::*;

   // The run is stopped by force if it goes past this many cycles, far more than the
   // slowest correct run takes, even with the longest idle bursts on both sides of
   // every beat.
   localparam int unsigned CYCLE_LIMIT = 250000;
   // Extra cycles after the last response give margin before a register write or
   // the end of the run.
   localparam int unsigned SETTLE_CYCLES = 6;
   // The long receiver hold-off of the back-pressure test.
   localparam int unsigned LONG_HOLD_CYCLES = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_RX_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_WRONG_ACK_LIMIT;
   logic [15:0] csr_wdata = '0;

   safety_link_heartbeat_monitor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Our own copy of the monitor's state and registers. It is advanced once for
   // every request beat, at the edge where the block accepts that beat.
   logic [7:0]  rx_line [PrefixDepth];
   logic [7:0]  rx_len      = '0;
   logic        ack_wait    = 1'b0;
   logic [7:0]  ack_char    = '0;
   logic [15:0] miss_count  = '0;
   logic [15:0] cfg_limit   = LIMIT_RESET;
   logic [7:0]  cfg_penalty = PENALTY_RESET;

   // Predicted responses, oldest first, waiting for their response beats.
   result_type  pending_rsp_q [$];
   result_type  want_rsp;

   // Bytes of the next line to be received; the newline is added on sending.
   logic [7:0]  line_text [$];

   int unsigned errors         = 0;
   int unsigned beats_sent     = 0;
   int unsigned beats_checked  = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_cycles    = 0;
   logic        sender_idle_on = 1'b1;
   logic        receiver_idle_on = 1'b1;

   initial begin
      for (int i = 0; i < PrefixDepth; i++) rx_line[i] = '0;
   end

   // Adds to the wrong-ack count, sticking at the top instead of wrapping.
   function automatic logic [15:0] sat_add(input logic [15:0] count, input logic [15:0] amount);
      logic [16:0] sum;
      sum = {1'b0, count} + {1'b0, amount};
      return sum[16] ? COUNT_MAX : sum[15:0];
   endfunction

   // Works out the response to one request beat and advances the copied state.
   function automatic result_type link_predict(input item_type beat);
      result_type rsp;
      logic       is_ack;
      logic       is_trip;
      logic [7:0] tone;
      rsp = '0;
      rsp.line_outcome = OUTCOME_NONE;
      rsp.trip_request = TRIP_REQ_NONE;
      case (beat.operation)
         OP_RX_BYTE: begin
            if (beat.rx_byte != CHAR_NEWLINE) begin
               // Only the head of the line is kept; the length still counts on.
               if (rx_len < PrefixDepth) rx_line[rx_len[2:0]] = beat.rx_byte;
               if (rx_len != LEN_MAX) rx_len = rx_len + 8'd1;
            end else begin
               is_ack = (rx_len >= 3) && rx_line[0] == CHAR_A && rx_line[1] == CHAR_C
                        && rx_line[2] == CHAR_K;
               is_trip = (rx_len >= 4) && rx_line[0] == CHAR_T && rx_line[1] == CHAR_R
                         && rx_line[2] == CHAR_I && rx_line[3] == CHAR_P;
               if (is_ack) begin
                  // Only "ACK x" for the byte we are waiting on counts as good.
                  if (ack_wait && rx_len == 8'd5 && rx_line[3] == CHAR_SPACE
                      && rx_line[4] == ack_char) begin
                     miss_count = '0;
                     rsp.line_outcome = OUTCOME_ACK_OK;
                  end else begin
                     miss_count = sat_add(miss_count, 16'd1);
                     rsp.line_outcome = OUTCOME_ACK_WRONG;
                  end
                  ack_wait = 1'b0;
               end else if (is_trip) begin
                  rsp.trip_request = TRIP_REQ_REMOTE;
               end else begin
                  rsp.line_outcome = OUTCOME_OTHER;
               end
               for (int i = 0; i < PrefixDepth; i++) rx_line[i] = '0;
               rx_len = '0;
            end
         end
         OP_HEARTBEAT: begin
            if (beat.trip_state != TRIP_STATE_CLEAR && beat.trip_state != TRIP_STATE_REMOTE)
               tone = CHAR_E;
            else
               tone = beat.heartbeat_level ? CHAR_PLUS : CHAR_MINUS;
            rsp.tx_valid = 1'b1;
            rsp.tx_char  = tone;
            if (!ack_wait) begin
               ack_wait = 1'b1;
               ack_char = tone;
            end else begin
               miss_count = sat_add(miss_count, {8'd0, cfg_penalty});
            end
         end
         OP_SEND_CMD: begin
            if (!ack_wait) begin
               rsp.tx_valid = 1'b1;
               rsp.tx_char  = beat.command_char;
               rsp.command_accepted = 1'b1;
               ack_wait = 1'b1;
               ack_char = beat.command_char;
            end else begin
               miss_count = sat_add(miss_count, 16'd1);
            end
         end
         default: begin
            if (miss_count > cfg_limit && beat.trip_state == TRIP_STATE_CLEAR)
               rsp.trip_request = TRIP_REQ_ACK_FAIL;
         end
      endcase
      rsp.wrong_count_now = miss_count;
      return rsp;
   endfunction

   // Offers one request beat, with a random idle burst in front of it at times,
   // and waits until the block takes it. The valid stays high on return so that
   // back-to-back beats need no gap; wait_idle lowers it.
   task automatic send_beat(input op_type op, input logic [7:0] rx, input logic [7:0] cmd,
                            input logic [2:0] trip, input logic level);
      item_type beat;
      int unsigned gap;
      beat.operation       = op;
      beat.rx_byte         = rx;
      beat.command_char    = cmd;
      beat.trip_state      = trip;
      beat.heartbeat_level = level;
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'h0, level, trip, cmd, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp_q.insert(pending_rsp_q.size(), link_predict(beat));
      beats_sent++;
   endtask

   // Fields that the operation does not use are filled at random so that every
   // input bit still toggles.
   task automatic send_rx(input logic [7:0] rx);
      send_beat(OP_RX_BYTE, rx, 8'($urandom), 3'($urandom), 1'($urandom));
   endtask

   task automatic send_heartbeat(input logic [2:0] trip, input logic level);
      send_beat(OP_HEARTBEAT, 8'($urandom), 8'($urandom), trip, level);
   endtask

   task automatic send_command(input logic [7:0] cmd);
      send_beat(OP_SEND_CMD, 8'($urandom), cmd, 3'($urandom), 1'($urandom));
   endtask

   task automatic send_monitor(input logic [2:0] trip);
      send_beat(OP_MONITOR, 8'($urandom), 8'($urandom), trip, 1'($urandom));
   endtask

   // Sends the bytes held in line_text and then the newline that ends the line.
   task automatic send_line();
      foreach (line_text[i]) send_rx(line_text[i]);
      send_rx(CHAR_NEWLINE);
   endtask

   // Appends one byte to the line that is being built.
   function automatic void append_text(input logic [7:0] b);
      line_text.insert(line_text.size(), b);
   endfunction

   function automatic void text_from(input string text);
      line_text.delete();
      for (int i = 0; i < text.len(); i++) append_text(text[i]);
   endfunction

   function automatic logic [7:0] rand_text_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == CHAR_NEWLINE) b = CHAR_SPACE;
      return b;
   endfunction

   // Trip states lean toward the two that change behavior, untripped and remote.
   function automatic logic [2:0] rand_trip();
      if ($urandom_range(0, 2) == 0) return 3'($urandom);
      return $urandom_range(0, 1) ? TRIP_STATE_CLEAR : TRIP_STATE_REMOTE;
   endfunction

   // Stops offering beats and waits until every predicted response has come
   // back, then a few cycles more so that the block is quiet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write, taken at the next edge. Only called while idle.
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_WRONG_ACK_LIMIT)
         cfg_limit = value;
      else
         cfg_penalty = value[7:0];
   endtask

   // The receiver: ready most of the time, with random idle bursts, and one
   // long hold-off when a test asks for it through hold_cycles.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   // Every response beat is matched against the oldest prediction. The response
   // word holds, from the lowest bit up: tx_valid, tx_char, line_outcome,
   // command_accepted, trip_request and wrong_count_now.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response beat %0h arrived with no prediction waiting", rsp_tdata);
            errors++;
         end else begin
            want_rsp = pending_rsp_q.pop_front();
            check_field("tx_valid", 16'(want_rsp.tx_valid), 16'(rsp_tdata[0]));
            check_field("tx_char", 16'(want_rsp.tx_char), 16'(rsp_tdata[8:1]));
            check_field("line_outcome", 16'(want_rsp.line_outcome), 16'(rsp_tdata[10:9]));
            check_field("command_accepted", 16'(want_rsp.command_accepted),
                        16'(rsp_tdata[11]));
            check_field("trip_request", 16'(want_rsp.trip_request), 16'(rsp_tdata[13:12]));
            check_field("wrong_count_now", want_rsp.wrong_count_now, rsp_tdata[29:14]);
            beats_checked++;
         end
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding", cycle_count,
                  pending_rsp_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Register values straight out of reset: one exchange of each kind.
   task automatic test_directed_basics();
      // Count is zero, so the monitor tick must not ask for a trip.
      send_monitor(TRIP_STATE_CLEAR);
      send_heartbeat(TRIP_STATE_CLEAR, 1'b0);
      text_from("ACK -");
      send_line();
      // A remote trip still sends the level; other trip states send 'E'.
      send_heartbeat(TRIP_STATE_REMOTE, 1'b1);
      send_heartbeat(3'd7, 1'b0);
      // The ack is still pending, so the command is refused and counted.
      send_command(8'h00);
      text_from("TRIP");
      send_line();
      // An empty line is just another line.
      line_text.delete();
      send_line();
      // A bare "ACK" is a wrong ack and ends the wait.
      text_from("ACK");
      send_line();
      send_command(8'hFF);
      send_heartbeat(3'd2, 1'b1);
      send_monitor(3'd7);
   endtask

   // Lines longer than the kept prefix, and lines too short to match anything.
   task automatic test_long_lines();
      send_heartbeat(TRIP_STATE_CLEAR, 1'b1);
      text_from("ACK +");
      append_text(rand_text_byte());
      send_line();
      text_from("TRIPPED");
      send_line();
      text_from("AC");
      send_line();
      text_from("TRI");
      send_line();
      send_heartbeat(TRIP_STATE_CLEAR, 1'b0);
      // Long enough that the line length sticks at its top value.
      line_text.delete();
      repeat (300) append_text(rand_text_byte());
      send_line();
      text_from("ACK -");
      send_line();
   endtask

   // Largest penalty drives the count into its ceiling; then the limit is
   // moved around it. The penalty write carries bits above its width.
   task automatic test_count_saturation();
      wait_idle();
      write_reg(CSR_WRONG_ACK_LIMIT, 16'hFFFF);
      write_reg(CSR_MISSED_ACK_PENALTY, 16'hFFFF);
      send_heartbeat(rand_trip(), 1'($urandom));
      repeat (260) send_heartbeat(rand_trip(), 1'($urandom));
      // A full count is not above a full limit.
      send_monitor(TRIP_STATE_CLEAR);
      wait_idle();
      write_reg(CSR_WRONG_ACK_LIMIT, 16'hFFFE);
      send_monitor(TRIP_STATE_CLEAR);
      send_monitor(TRIP_STATE_REMOTE);
      send_monitor(3'd1);
      wait_idle();
      write_reg(CSR_WRONG_ACK_LIMIT, 16'h0000);
      send_monitor(TRIP_STATE_CLEAR);
      // The matching ack brings the count back to zero.
      text_from("ACK ");
      append_text(ack_char);
      send_line();
      send_monitor(TRIP_STATE_CLEAR);
   endtask

   // One random exchange: mostly well-formed heartbeat, command and ack traffic,
   // with broken acks, trip lines, noise lines and monitor ticks mixed in.
   task automatic random_scenario();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_heartbeat(rand_trip(), 1'($urandom));
      end else if (pick < 35) begin
         send_command(8'($urandom));
      end else if (pick < 60) begin
         text_from("ACK ");
         append_text(ack_wait ? ack_char : 8'($urandom));
         send_line();
      end else if (pick < 70) begin
         case ($urandom_range(0, 4))
            0: text_from("AC");
            1: text_from("ACK");
            2: begin
               text_from("ACK");
               append_text(rand_text_byte());
               append_text(ack_char);
            end
            3: begin
               text_from("ACK ");
               append_text(ack_char ^ (8'd1 << $urandom_range(0, 7)));
            end
            default: begin
               text_from("ACK ");
               append_text(ack_char);
               append_text(rand_text_byte());
            end
         endcase
         send_line();
      end else if (pick < 77) begin
         text_from("TRIP");
         repeat ($urandom_range(0, 3)) append_text(rand_text_byte());
         send_line();
      end else if (pick < 87) begin
         // Noise: random bytes, a newline among them ends the line early.
         line_text.delete();
         len = $urandom_range(0, 6);
         repeat (len) append_text(8'($urandom));
         send_line();
      end else begin
         send_monitor($urandom_range(0, 4) < 3 ? TRIP_STATE_CLEAR : rand_trip());
      end
   endtask

   // The receiver stops for a long stretch while beats keep being offered, so
   // the block fills and stalls its request side.
   task automatic test_backpressure();
      int unsigned start;
      wait_idle();
      write_reg(CSR_WRONG_ACK_LIMIT, LIMIT_RESET);
      write_reg(CSR_MISSED_ACK_PENALTY, {8'd0, PENALTY_RESET});
      hold_cycles = LONG_HOLD_CYCLES;
      start = beats_sent;
      while (beats_sent - start < 60) random_scenario();
   endtask

   task automatic test_random_phase(input logic [15:0] limit, input logic [15:0] penalty,
                                    input int unsigned count);
      int unsigned start;
      wait_idle();
      write_reg(CSR_WRONG_ACK_LIMIT, limit);
      write_reg(CSR_MISSED_ACK_PENALTY, penalty);
      start = beats_sent;
      while (beats_sent - start < count) random_scenario();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_long_lines();
      test_count_saturation();
      test_backpressure();

      test_random_phase(LIMIT_RESET, {8'd0, PENALTY_RESET}, 210);
      test_random_phase(16'h0000, 16'h0000, 210);
      test_random_phase(16'hFFFF, 16'h00FF, 210);
      test_random_phase(16'($urandom), 16'($urandom), 210);
      // The last stretch runs with both sides always ready.
      wait_idle();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      test_random_phase(16'($urandom_range(0, 40)), 16'($urandom_range(1, 8)), 210);

      wait_idle();
      $display("Checked %0d responses to %0d request beats: directed exchanges, long lines,",
               beats_checked, beats_sent);
      $display("count saturation, a long receiver stall and five random register settings.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ safety_link_heartbeat_monitor.f @@
src/shlm_pkg.sv
src/shlm_line_buf.sv
src/shlm_ack_ctrl.sv
src/safety_link_heartbeat_monitor.sv
src/shlm_checker.sv
tb/sv/safety_link_heartbeat_monitor_tb.sv
